FILE: rtl/core/rotate_vertex_xyz_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vertex rotation block
// Short forms for the implication checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ROTATE_VERTEX_XYZ_MACROS_SVH
`define ROTATE_VERTEX_XYZ_MACROS_SVH

// same-cycle implication, disabled during reset
`define RVX_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define RVX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/rvx_pkg.sv
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared types, register codes and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package rvx_pkg;

  localparam int unsigned ANGLE_BITS   = 9;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned TABLE_FRAC   = 14;
  localparam int unsigned TABLE_BITS   = 15;
  localparam int unsigned TABLE_IDX_W  = 7;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ANGLE_X = 2'd0,
    REG_ANGLE_Y = 2'd1,
    REG_ANGLE_Z = 2'd2
  } cfg_reg_e;

  typedef logic [ANGLE_BITS-1:0] angle_t;

  // table address plus sign of the looked-up value
  typedef struct packed {
    logic [TABLE_IDX_W-1:0] idx;
    logic                   neg;
  } trig_ref_t;

  // sin(k deg), k = 0..90, Q1.14
  localparam logic [TABLE_BITS-1:0] SIN_Q14 [91] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // 360..511 folds back once
  function automatic angle_t wrap_angle(input angle_t a);
    angle_t r;
    r = a;
    if (a >= ANGLE_BITS'(360)) begin
      r = a - ANGLE_BITS'(360);
    end
    return r;
  endfunction

  // quadrant fold of an angle already in 0..359
  function automatic trig_ref_t sin_ref(input angle_t a);
    trig_ref_t r;
    r.neg = 1'b0;
    if (a <= ANGLE_BITS'(90)) begin
      r.idx = TABLE_IDX_W'(a);
    end else if (a <= ANGLE_BITS'(180)) begin
      r.idx = TABLE_IDX_W'(ANGLE_BITS'(180) - a);
    end else if (a <= ANGLE_BITS'(270)) begin
      r.idx = TABLE_IDX_W'(a - ANGLE_BITS'(180));
      r.neg = 1'b1;
    end else begin
      r.idx = TABLE_IDX_W'(ANGLE_BITS'(360) - a);
      r.neg = 1'b1;
    end
    return r;
  endfunction

  // cos(a) = sin(a + 90), folded into 0..359
  function automatic trig_ref_t cos_ref(input angle_t a);
    logic [ANGLE_BITS:0] s;
    s = {1'b0, a} + (ANGLE_BITS+1)'(90);
    if (s >= (ANGLE_BITS+1)'(360)) begin
      s = s - (ANGLE_BITS+1)'(360);
    end
    return sin_ref(s[ANGLE_BITS-1:0]);
  endfunction

endpackage

FILE: rtl/core/rvx_ifs.sv
// ----------------------------------------------------------------------------
// rvx channel interfaces
// Valid/ready channels for vertices in, rotated vertices out, and config.
// ----------------------------------------------------------------------------
interface rvx_vertex_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic signed [COORD_BITS-1:0] vertex_z;

  modport source (output valid, vertex_x, vertex_y, vertex_z, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, output ready);
endinterface

interface rvx_rotated_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] rotated_x;
  logic signed [COORD_BITS-1:0] rotated_y;
  logic signed [COORD_BITS-1:0] rotated_z;

  modport source (output valid, rotated_x, rotated_y, rotated_z, input ready);
  modport sink   (input valid, rotated_x, rotated_y, rotated_z, output ready);
endinterface

interface rvx_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rvx_pkg::CFG_IDX_BITS-1:0] index;
  logic [rvx_pkg::ANGLE_BITS-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/rotate_vertex_xyz.sv
// ----------------------------------------------------------------------------
// rotate_vertex_xyz
// Fixed-point Euler X-Y-Z rotation of one 3D vertex per transaction.
// ----------------------------------------------------------------------------
//  channel  dir  payload                              accepted when
//  vtx_i    in   vertex_x/y/z, signed Q7.8            vtx_i.valid & vtx_i.ready
//  rot_o    out  rotated_x/y/z, signed Q7.8, sat      rot_o.valid & rot_o.ready
//  cfg_i    in   index (0=X,1=Y,2=Z), 9-bit degrees   cfg_i.valid & cfg_i.ready
//
//  Six register stages, one vertex per cycle while rot_o is not stalled;
//  rot_o.valid is the valid bit of the last stage.
//  Each axis takes two stages: four multipliers, then add/round/saturate.
//  Stages advance on their own ready, so bubbles close up under a stall and
//  input is taken while a result waits in the output stage if a stage is empty.
//  Reset clears the valid bits and sets all angles to 0 (cos = 1, sin = 0).
//  cfg_i is always ready; the sine/cosine lookup happens at write time.
// ----------------------------------------------------------------------------
`include "rotate_vertex_xyz_macros.svh"

module rotate_vertex_xyz #(
  parameter int unsigned COORD_BITS     = 16,
  parameter int unsigned TRIG_FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  rvx_vertex_if.sink         vtx_i,
  rvx_rotated_if.source      rot_o,
  rvx_cfg_if.sink            cfg_i
);
  import rvx_pkg::*;

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned F  = TRIG_FRAC_BITS;
  localparam int unsigned TW = F + 2;    // coefficient, holds +-1.0
  localparam int unsigned PW = CW + TW;  // one product
  localparam int unsigned SW = PW + 1;   // sum of two products
  localparam int unsigned NSTAGE = 6;

  localparam int unsigned SH_UP = (F >= TABLE_FRAC) ? F - TABLE_FRAC : 0;
  localparam int unsigned SH_DN = (F <  TABLE_FRAC) ? TABLE_FRAC - F : 0;
  localparam int unsigned XW    = TW + TABLE_BITS + 1;

  localparam logic [XW-1:0] TAB_RND = (SH_DN > 0) ? (XW'(1) << (SH_DN - 1)) : '0;
  localparam logic signed [TW-1:0] COEF_ONE = TW'(1) << F;
  localparam logic signed [SW-1:0] HALF     = SW'(1) << (F - 1);
  localparam logic signed [SW-1:0] SAT_HI   = SW'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic signed [SW-1:0] SAT_LO   = -SAT_HI - SW'(1);

  // table entry rescaled to Q1.F, sign applied
  function automatic logic signed [TW-1:0] coef(input trig_ref_t r);
    logic [XW-1:0]          t;
    logic signed [TW-1:0]   m;
    t = XW'(SIN_Q14[r.idx]);
    if (F >= TABLE_FRAC) begin
      t = t << SH_UP;
    end else begin
      t = (t + TAB_RND) >> SH_DN;
    end
    m = $signed(t[TW-1:0]);
    return r.neg ? -m : m;
  endfunction

  // add half, floor to the coordinate fraction, clamp
  function automatic logic signed [CW-1:0] rnd_sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    t = (v + HALF) >>> F;
    if (t > SAT_HI) begin
      t = SAT_HI;
    end else if (t < SAT_LO) begin
      t = SAT_LO;
    end
    return t[CW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Coefficient registers, index 0..2 = X, Y, Z
  // --------------------------------------------------------------------------
  logic signed [TW-1:0] cos_q [3];
  logic signed [TW-1:0] sin_q [3];
  angle_t               cfg_angle;
  logic                 cfg_fire;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign cfg_angle   = wrap_angle(cfg_i.data);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        cos_q[i] <= COEF_ONE;
        sin_q[i] <= '0;
      end
    end else if (cfg_fire) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_ANGLE_X: begin
          cos_q[0] <= coef(cos_ref(cfg_angle));
          sin_q[0] <= coef(sin_ref(cfg_angle));
        end
        REG_ANGLE_Y: begin
          cos_q[1] <= coef(cos_ref(cfg_angle));
          sin_q[1] <= coef(sin_ref(cfg_angle));
        end
        REG_ANGLE_Z: begin
          cos_q[2] <= coef(cos_ref(cfg_angle));
          sin_q[2] <= coef(sin_ref(cfg_angle));
        end
        default: begin
          // index past the register list: ignored
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control
  // --------------------------------------------------------------------------
  logic [NSTAGE:1] v_q;
  logic [NSTAGE:1] rdy;

  always_comb begin
    rdy[NSTAGE] = rot_o.ready || !v_q[NSTAGE];
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      rdy[k] = rdy[k+1] || !v_q[k];
    end
  end

  assign vtx_i.ready = rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[1]) begin
        v_q[1] <= vtx_i.valid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  // X axis: y' = c*y - s*z, z' = s*y + c*z
  logic signed [CW-1:0] x1_q, x2_q, y2_q, z2_q;
  logic signed [PW-1:0] p1a_q, p1b_q, p1c_q, p1d_q;
  // Y axis: x' = c*x + s*z, z' = c*z - s*x
  logic signed [CW-1:0] y3_q, x4_q, y4_q, z4_q;
  logic signed [PW-1:0] p3a_q, p3b_q, p3c_q, p3d_q;
  // Z axis: x' = c*x - s*y, y' = s*x + c*y
  logic signed [CW-1:0] z5_q, x6_q, y6_q, z6_q;
  logic signed [PW-1:0] p5a_q, p5b_q, p5c_q, p5d_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      x1_q  <= vtx_i.vertex_x;
      p1a_q <= vtx_i.vertex_y * cos_q[0];
      p1b_q <= vtx_i.vertex_z * sin_q[0];
      p1c_q <= vtx_i.vertex_y * sin_q[0];
      p1d_q <= vtx_i.vertex_z * cos_q[0];
    end
    if (rdy[2]) begin
      x2_q <= x1_q;
      y2_q <= rnd_sat(SW'(p1a_q) - SW'(p1b_q));
      z2_q <= rnd_sat(SW'(p1c_q) + SW'(p1d_q));
    end
    if (rdy[3]) begin
      y3_q  <= y2_q;
      p3a_q <= x2_q * cos_q[1];
      p3b_q <= z2_q * sin_q[1];
      p3c_q <= z2_q * cos_q[1];
      p3d_q <= x2_q * sin_q[1];
    end
    if (rdy[4]) begin
      y4_q <= y3_q;
      x4_q <= rnd_sat(SW'(p3a_q) + SW'(p3b_q));
      z4_q <= rnd_sat(SW'(p3c_q) - SW'(p3d_q));
    end
    if (rdy[5]) begin
      z5_q  <= z4_q;
      p5a_q <= x4_q * cos_q[2];
      p5b_q <= y4_q * sin_q[2];
      p5c_q <= x4_q * sin_q[2];
      p5d_q <= y4_q * cos_q[2];
    end
    if (rdy[6]) begin
      z6_q <= z5_q;
      x6_q <= rnd_sat(SW'(p5a_q) - SW'(p5b_q));
      y6_q <= rnd_sat(SW'(p5c_q) + SW'(p5d_q));
    end
  end

  assign rot_o.valid     = v_q[NSTAGE];
  assign rot_o.rotated_x = x6_q;
  assign rot_o.rotated_y = y6_q;
  assign rot_o.rotated_z = z6_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // an empty output stage means nothing upstream can be blocked
  `RVX_ASSERT_SAME(a_ready_when_out_empty, clk_i, rst_ni, !v_q[NSTAGE], vtx_i.ready, "input stalled with empty output stage")
  // a valid item next to an open slot moves into it
  `RVX_ASSERT_NEXT(a_last_stage_fills, clk_i, rst_ni, v_q[NSTAGE-1] && rdy[NSTAGE], v_q[NSTAGE], "item lost before output stage")
  // zero degrees on X loads unit cosine and zero sine
  `RVX_ASSERT_NEXT(a_zero_angle_coef, clk_i, rst_ni, cfg_fire && (cfg_i.index == REG_ANGLE_X) && (cfg_i.data == '0), (cos_q[0] == COEF_ONE) && (sin_q[0] == '0), "bad coefficients for zero angle")

endmodule
